/* rtl/tftprc_pkg.sv */
// tftprc_pkg: types, codes and constants for the tftp read client engine
// no dependencies; used by every other file of the block but tftprc_if_top_note
`default_nettype none
package tftprc_pkg;

  // field widths of the channel words
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned PORT_LEN = 24;
  localparam int unsigned STLEN_W  = 10;
  localparam int unsigned RETRY_W  = 8;
  localparam int unsigned NAK_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // parameter defaults
  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam int unsigned LEN_BITS_DEF    = 24;

  // protocol constants
  localparam logic [HALF_W-1:0] OP_DATA   = 16'd3;
  localparam logic [HALF_W-1:0] OP_ERROR  = 16'd5;
  localparam logic [HALF_W-1:0] HDR_BYTES = 16'd12;
  localparam logic [NAK_W-1:0]  NAK_FIRST = 5'd3;
  localparam logic [NAK_W-1:0]  NAK_LATER = 5'd30;

  localparam logic [PORT_LEN-1:0] MAX_BYTES_RST   = 24'hFF_FFFF;
  localparam logic [RETRY_W-1:0]  RETRY_LIMIT_RST = 8'd8;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;
  localparam int unsigned Q_CW    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BYTES   = 1'd0,
    CFG_RETRY_LIMIT = 1'd1
  } cfg_idx_e;

  typedef enum logic [FUNC_W-1:0] {
    FN_START   = 2'd0,
    FN_PACKET  = 2'd1,
    FN_TIMEOUT = 2'd2,
    FN_UNUSED  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_TIMEOUT,
    CMD_ERROR,
    CMD_BADOP,
    CMD_DATA,
    CMD_NOP
  } cmd_e;

  typedef enum logic [1:0] {
    SEND_NONE = 2'd0,
    SEND_RRQ  = 2'd1,
    SEND_ACK  = 2'd2,
    SEND_NAK  = 2'd3
  } send_e;

  typedef enum logic [1:0] {
    OUT_RUNNING = 2'd0,
    OUT_DONE    = 2'd1,
    OUT_ERROR   = 2'd2,
    OUT_RETRIES = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    PS_NONE     = 3'd0,
    PS_BADOP    = 3'd1,
    PS_BADBLOCK = 3'd2,
    PS_OVERSIZE = 3'd3,
    PS_OVERFLOW = 3'd4,
    PS_ACCEPTED = 3'd5
  } pstat_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_END  = 2'd2
  } phase_e;

  // classified event handed from front to back
  typedef struct packed {
    cmd_e              kind;
    logic [HALF_W-1:0] block_number;
    logic [HALF_W-1:0] plen;
    logic              oversize;
    logic              short_blk;
  } cmd_t;

  // result word held in the output register
  typedef struct packed {
    send_e               send_kind;
    logic [HALF_W-1:0]   ack_block;
    logic                store_enable;
    logic [PORT_LEN-1:0] store_offset;
    logic [STLEN_W-1:0]  store_length;
    logic [PORT_LEN-1:0] bytes_so_far;
    outcome_e            outcome;
    pstat_e              packet_status;
  } res_t;

endpackage
`default_nettype wire

/* rtl/tftprc_evt_if.sv */
// tftprc_evt_if: event channel (valid/ready plus header fields)
// depends on tftprc_pkg for field widths
`default_nettype none
interface tftprc_evt_if;
  logic                           valid;
  logic                           ready;
  logic [tftprc_pkg::FUNC_W-1:0]  func;
  logic [tftprc_pkg::HALF_W-1:0]  opcode;
  logic [tftprc_pkg::HALF_W-1:0]  block_number;
  logic [tftprc_pkg::HALF_W-1:0]  udp_length;

  modport source (output valid, func, opcode, block_number, udp_length, input ready);
  modport sink   (input valid, func, opcode, block_number, udp_length, output ready);
endinterface
`default_nettype wire

/* rtl/tftprc_res_if.sv */
// tftprc_res_if: result channel (valid/ready plus result fields)
// depends on tftprc_pkg for field widths
`default_nettype none
interface tftprc_res_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      send_kind;
  logic [tftprc_pkg::HALF_W-1:0]   ack_block;
  logic                            store_enable;
  logic [tftprc_pkg::PORT_LEN-1:0] store_offset;
  logic [tftprc_pkg::STLEN_W-1:0]  store_length;
  logic [tftprc_pkg::PORT_LEN-1:0] bytes_so_far;
  logic [1:0]                      outcome;
  logic [2:0]                      packet_status;

  modport source (output valid, send_kind, ack_block, store_enable, store_offset,
                  store_length, bytes_so_far, outcome, packet_status, input ready);
  modport sink   (input valid, send_kind, ack_block, store_enable, store_offset,
                  store_length, bytes_so_far, outcome, packet_status, output ready);
endinterface
`default_nettype wire

/* rtl/tftprc_front.sv */
// tftprc_front: takes event words and classifies them for the back end
// depends on tftprc_pkg and tftprc_evt_if
`default_nettype none
module tftprc_front #(
  parameter int unsigned BLOCK_BYTES = tftprc_pkg::BLOCK_BYTES_DEF
) (
  tftprc_evt_if.sink        evt_i,
  input  wire logic         q_ready_i,
  output tftprc_pkg::cmd_t  cmd_o,
  output logic              push_o
);

  logic [tftprc_pkg::HALF_W-1:0] plen;
  logic [tftprc_pkg::HALF_W-1:0] blk_bytes;

  assign blk_bytes   = tftprc_pkg::HALF_W'(BLOCK_BYTES);
  assign evt_i.ready = q_ready_i;
  assign push_o      = evt_i.valid && q_ready_i;

  // payload length wraps in 16 bits
  assign plen = evt_i.udp_length - tftprc_pkg::HDR_BYTES;

  always_comb begin
    cmd_o.block_number = evt_i.block_number;
    cmd_o.plen         = plen;
    cmd_o.oversize     = plen > blk_bytes;
    cmd_o.short_blk    = plen < blk_bytes;
    case (tftprc_pkg::func_e'(evt_i.func))
      tftprc_pkg::FN_START:   cmd_o.kind = tftprc_pkg::CMD_START;
      tftprc_pkg::FN_TIMEOUT: cmd_o.kind = tftprc_pkg::CMD_TIMEOUT;
      tftprc_pkg::FN_PACKET: begin
        if (evt_i.opcode == tftprc_pkg::OP_ERROR) begin
          cmd_o.kind = tftprc_pkg::CMD_ERROR;
        end else if (evt_i.opcode == tftprc_pkg::OP_DATA) begin
          cmd_o.kind = tftprc_pkg::CMD_DATA;
        end else begin
          cmd_o.kind = tftprc_pkg::CMD_BADOP;
        end
      end
      default: cmd_o.kind = tftprc_pkg::CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/tftprc_queue.sv */
// tftprc_queue: short fifo of classified events between front and back
// depends on tftprc_pkg
`default_nettype none
module tftprc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tftprc_pkg::cmd_t  cmd_i,
  output logic                   ready_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output tftprc_pkg::cmd_t       cmd_o
);

  tftprc_pkg::cmd_t mem_q [tftprc_pkg::Q_DEPTH];

  logic [tftprc_pkg::Q_AW-1:0] wr_q, wr_d;
  logic [tftprc_pkg::Q_AW-1:0] rd_q, rd_d;
  logic [tftprc_pkg::Q_CW-1:0] cnt_q, cnt_d;

  assign ready_o = cnt_q != tftprc_pkg::Q_CW'(tftprc_pkg::Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tftprc_pkg::Q_CW'(tftprc_pkg::Q_DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

/* rtl/tftprc_back.sv */
// tftprc_back: transfer state, event execution and result register
// depends on tftprc_pkg and tftprc_res_if
`default_nettype none
module tftprc_back #(
  parameter int unsigned LEN_BITS = tftprc_pkg::LEN_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [tftprc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tftprc_pkg::PORT_LEN-1:0]    cfg_wdata_i,
  input  wire logic                               cmd_valid_i,
  input  wire tftprc_pkg::cmd_t                   cmd_i,
  output logic                                    cmd_ready_o,
  tftprc_res_if.source                            res_o
);

  logic [tftprc_pkg::PORT_LEN-1:0] max_q;
  logic [tftprc_pkg::RETRY_W-1:0]  rlim_q;

  logic [tftprc_pkg::HALF_W-1:0]   exp_q, exp_d;
  logic [LEN_BITS-1:0]             rcv_q, rcv_d;
  logic [LEN_BITS-1:0]             lim_q, lim_d;
  logic [tftprc_pkg::NAK_W-1:0]    nak_q, nak_d;
  logic [tftprc_pkg::RETRY_W-1:0]  ret_q, ret_d;
  tftprc_pkg::phase_e              ph_q, ph_d;
  tftprc_pkg::outcome_e            fin_q, fin_d;

  logic                            out_vld_q;
  tftprc_pkg::res_t                res_q, res_d;

  logic                            pop;
  logic                            running;
  logic                            do_rej;
  logic                            do_req;
  tftprc_pkg::send_e               rej_send;
  tftprc_pkg::send_e               req_other;
  tftprc_pkg::send_e               send;
  logic [LEN_BITS:0]               sum_ext;
  logic [LEN_BITS-1:0]             plen_ext;

  assign cmd_ready_o = !out_vld_q || res_o.ready;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign running     = ph_q == tftprc_pkg::PH_RUN;
  assign plen_ext    = LEN_BITS'(cmd_i.plen);
  assign sum_ext     = {1'b0, rcv_q} + {1'b0, plen_ext};

  always_comb begin
    exp_d     = exp_q;
    rcv_d     = rcv_q;
    lim_d     = lim_q;
    nak_d     = nak_q;
    ret_d     = ret_q;
    ph_d      = ph_q;
    fin_d     = fin_q;
    send      = tftprc_pkg::SEND_NONE;
    do_rej    = 1'b0;
    do_req    = 1'b0;
    rej_send  = tftprc_pkg::SEND_NONE;
    req_other = tftprc_pkg::SEND_NONE;
    res_d     = '0;

    case (cmd_i.kind)
      tftprc_pkg::CMD_START: begin
        exp_d  = 16'd1;
        rcv_d  = '0;
        lim_d  = LEN_BITS'(max_q);
        nak_d  = '0;
        ret_d  = rlim_q;
        ph_d   = tftprc_pkg::PH_RUN;
        fin_d  = tftprc_pkg::OUT_RUNNING;
        do_req = 1'b1;
      end
      tftprc_pkg::CMD_TIMEOUT: begin
        do_rej = running;
      end
      tftprc_pkg::CMD_ERROR: begin
        if (running) begin
          ph_d  = tftprc_pkg::PH_END;
          fin_d = tftprc_pkg::OUT_ERROR;
        end
      end
      tftprc_pkg::CMD_BADOP: begin
        if (running) begin
          res_d.packet_status = tftprc_pkg::PS_BADOP;
          do_rej = 1'b1;
        end
      end
      tftprc_pkg::CMD_DATA: begin
        if (running) begin
          if (cmd_i.block_number != exp_q) begin
            res_d.packet_status = tftprc_pkg::PS_BADBLOCK;
            do_rej = 1'b1;
          end else begin
            exp_d = exp_q + 1'b1;
            send  = tftprc_pkg::SEND_ACK;
            if (cmd_i.oversize) begin
              res_d.packet_status = tftprc_pkg::PS_OVERSIZE;
              do_rej   = 1'b1;
              rej_send = tftprc_pkg::SEND_ACK;
            end else if (sum_ext > {1'b0, lim_q}) begin
              res_d.packet_status = tftprc_pkg::PS_OVERFLOW;
              do_rej   = 1'b1;
              rej_send = tftprc_pkg::SEND_ACK;
            end else begin
              res_d.packet_status = tftprc_pkg::PS_ACCEPTED;
              res_d.store_enable  = 1'b1;
              res_d.store_offset  = tftprc_pkg::PORT_LEN'(rcv_q);
              res_d.store_length  = cmd_i.plen[tftprc_pkg::STLEN_W-1:0];
              rcv_d = sum_ext[LEN_BITS-1:0];
              if (cmd_i.short_blk) begin
                lim_d = rcv_d;
              end
              nak_d = (rcv_d == '0) ? tftprc_pkg::NAK_FIRST : tftprc_pkg::NAK_LATER;
              if (rcv_d == lim_d) begin
                ph_d  = tftprc_pkg::PH_END;
                fin_d = tftprc_pkg::OUT_DONE;
              end
            end
          end
        end
      end
      default: ;
    endcase

    // spend nak budget, falling back to a resent request when it runs out
    if (do_rej) begin
      if (nak_q <= 5'd1) begin
        nak_d     = '0;
        do_req    = 1'b1;
        req_other = rej_send;
      end else begin
        nak_d = nak_q - 1'b1;
        send  = (rej_send == tftprc_pkg::SEND_ACK) ? tftprc_pkg::SEND_ACK
                                                   : tftprc_pkg::SEND_NAK;
      end
    end

    // read request, bounded by the retry budget
    if (do_req) begin
      if (ret_d == '0) begin
        ph_d  = tftprc_pkg::PH_END;
        fin_d = tftprc_pkg::OUT_RETRIES;
        send  = req_other;
      end else begin
        ret_d = ret_d - 1'b1;
        nak_d = (rcv_d == '0) ? tftprc_pkg::NAK_FIRST : tftprc_pkg::NAK_LATER;
        if (rcv_d == lim_d) begin
          ph_d  = tftprc_pkg::PH_END;
          fin_d = tftprc_pkg::OUT_DONE;
        end
        send = tftprc_pkg::SEND_RRQ;
      end
    end

    res_d.send_kind    = send;
    res_d.ack_block    = (send == tftprc_pkg::SEND_ACK) ? cmd_i.block_number : '0;
    res_d.bytes_so_far = tftprc_pkg::PORT_LEN'(rcv_d);
    res_d.outcome      = (ph_d == tftprc_pkg::PH_END) ? fin_d : tftprc_pkg::OUT_RUNNING;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= tftprc_pkg::MAX_BYTES_RST;
      rlim_q    <= tftprc_pkg::RETRY_LIMIT_RST;
      exp_q     <= 16'd1;
      rcv_q     <= '0;
      lim_q     <= '0;
      nak_q     <= '0;
      ret_q     <= '0;
      ph_q      <= tftprc_pkg::PH_IDLE;
      fin_q     <= tftprc_pkg::OUT_RUNNING;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tftprc_pkg::CFG_MAX_BYTES:   max_q  <= cfg_wdata_i;
          tftprc_pkg::CFG_RETRY_LIMIT: rlim_q <= cfg_wdata_i[tftprc_pkg::RETRY_W-1:0];
          default: ;
        endcase
      end
      if (pop) begin
        exp_q <= exp_d;
        rcv_q <= rcv_d;
        lim_q <= lim_d;
        nak_q <= nak_d;
        ret_q <= ret_d;
        ph_q  <= ph_d;
        fin_q <= fin_d;
      end
      if (cmd_ready_o) begin
        out_vld_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.send_kind     = res_q.send_kind;
  assign res_o.ack_block     = res_q.ack_block;
  assign res_o.store_enable  = res_q.store_enable;
  assign res_o.store_offset  = res_q.store_offset;
  assign res_o.store_length  = res_q.store_length;
  assign res_o.bytes_so_far  = res_q.bytes_so_far;
  assign res_o.outcome       = res_q.outcome;
  assign res_o.packet_status = res_q.packet_status;

`ifndef SYNTHESIS
  a_end_has_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == tftprc_pkg::PH_END |-> fin_q != tftprc_pkg::OUT_RUNNING)
    else $error("finished transfer without outcome");
  a_nak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nak_q <= tftprc_pkg::NAK_LATER)
    else $error("nak budget beyond limit");
  a_store_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.store_enable |->
      res_q.packet_status == tftprc_pkg::PS_ACCEPTED)
    else $error("store without accepted packet");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && ph_q == tftprc_pkg::PH_IDLE && cmd_i.kind != tftprc_pkg::CMD_START |=>
      res_q.send_kind == tftprc_pkg::SEND_NONE)
    else $error("send while idle");
`endif

endmodule
`default_nettype wire

/* rtl/tftprc_if_top_note.sv */
// tftprc_if_top_note: holds no logic, the channels sit in tftprc_evt_if and tftprc_res_if
// no dependencies
`default_nettype none
`default_nettype wire

/* rtl/tftp_read_client_engine_top.sv */
// tftp_read_client_engine_top: tftp read client header engine, top level
// depends on tftprc_pkg, tftprc_evt_if, tftprc_res_if, tftprc_front,
// tftprc_queue and tftprc_back
//
//   channel   dir  handshake      word
//   evt_i     in   valid/ready    func, opcode, block_number, udp_length
//   res_o     out  valid/ready    send_kind .. packet_status, one per event
//   cfg       in   cfg_we_i only  register index and write data
//
// one event word a cycle sustained while res_o takes its words; an accepted word
// is written into the queue, then popped into the back's result register for res_o
// rst_ni clears the transfer state, the queue and the result valid flag at once
// a stalled res_o holds its word; the two-entry queue keeps evt_i open
// until it fills, so the front and back stall independently
`default_nettype none
module tftp_read_client_engine_top #(
  parameter int unsigned BLOCK_BYTES = tftprc_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned LEN_BITS    = tftprc_pkg::LEN_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [tftprc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tftprc_pkg::PORT_LEN-1:0]  cfg_wdata_i,
  tftprc_evt_if.sink                            evt_i,
  tftprc_res_if.source                          res_o
);

  // classified word from the front, straight into the queue
  tftprc_pkg::cmd_t push_cmd;
  logic             push;
  logic             q_ready;

  // queue head towards the back end
  tftprc_pkg::cmd_t head_cmd;
  logic             head_valid;
  logic             head_pop;
  logic             head_pop_rdy;

  // front: decodes func and opcode, works out the payload length and its size class
  tftprc_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .evt_i     (evt_i),
    .q_ready_i (q_ready),
    .cmd_o     (push_cmd),
    .push_o    (push)
  );

  // short queue between the two halves
  tftprc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  // back: transfer state, nak and retry budgets, result register
  tftprc_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_ready_o (head_pop_rdy),
    .res_o       (res_o)
  );

  // pop only when the back end takes the head word
  assign head_pop = head_valid && head_pop_rdy;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for tftp_read_client_engine_top with its own reply predictor
// depends on tftprc_pkg, tftprc_evt_if, tftprc_res_if and the engine rtl
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tftprc_pkg::*;

  // header event as the bench builds it before it goes onto the channel
  typedef struct packed {
    func_e             func;
    logic [HALF_W-1:0] opcode;
    logic [HALF_W-1:0] blk;
    logic [HALF_W-1:0] ulen;
  } hdr_evt_t;

  localparam int unsigned BLK_BYTES   = BLOCK_BYTES_DEF;
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int unsigned LONG_HOLD   = 150;   // receiver hold-off, fills the engine

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  // config port, idle from time zero
  logic                cfg_we    = 1'b0;
  cfg_idx_e            cfg_idx   = CFG_MAX_BYTES;
  logic [PORT_LEN-1:0] cfg_wdata = '0;

  tftprc_evt_if evt_ch ();
  tftprc_res_if res_ch ();

  tftp_read_client_engine_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .evt_i       (evt_ch),
    .res_o       (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hdr_evt_t hdr_queue[$];       // events waiting for the driver
  res_t     expected_replies[$]; // predicted reply words, oldest first
  int       mismatches    = 0;
  int       gen_count     = 0;
  int       send_idle_pct = 28;
  int       recv_idle_pct = 65;

  // ---------------------------------------------------------------------------
  // reply predictor: shadow copy of the transfer state and of both registers
  // ---------------------------------------------------------------------------
  logic [PORT_LEN-1:0] cfg_max_bytes   = MAX_BYTES_RST;
  logic [RETRY_W-1:0]  cfg_retry_limit = RETRY_LIMIT_RST;

  logic [HALF_W-1:0]   next_block   = 16'd1;
  logic [PORT_LEN-1:0] rx_bytes     = '0;
  logic [PORT_LEN-1:0] size_limit   = '0;
  logic [NAK_W-1:0]    nak_left     = '0;
  logic [RETRY_W-1:0]  rrq_left     = '0;
  phase_e              xfer_phase   = PH_IDLE;
  outcome_e            xfer_outcome = OUT_RUNNING;

  // nak allowance is small until the first payload byte has landed
  function automatic logic [NAK_W-1:0] fresh_naks();
    return (rx_bytes == '0) ? NAK_FIRST : NAK_LATER;
  endfunction

  function automatic void close_xfer(outcome_e code);
    xfer_phase   = PH_END;
    xfer_outcome = code;
  endfunction

  // (re)send the read request while retries remain, else the transfer gives up
  function automatic send_e resend_rrq(send_e other);
    if (rrq_left == '0) begin
      close_xfer(OUT_RETRIES);
      return other;
    end
    rrq_left = rrq_left - 1'b1;
    nak_left = fresh_naks();
    if (rx_bytes == size_limit) close_xfer(OUT_DONE);
    return SEND_RRQ;
  endfunction

  // a rejected packet or a timeout eats one nak; an ack going out wins over the nak
  function automatic send_e spend_nak(send_e pending);
    if (nak_left <= 1) begin
      nak_left = '0;
      return resend_rrq(pending);
    end
    nak_left = nak_left - 1'b1;
    return (pending == SEND_ACK) ? pending : SEND_NAK;
  endfunction

  function automatic res_t predict_reply(hdr_evt_t e);
    res_t              r;
    logic [HALF_W-1:0] plen;
    r = '0;
    r.send_kind     = SEND_NONE;
    r.packet_status = PS_NONE;
    if (e.func == FN_START) begin
      next_block   = 16'd1;
      rx_bytes     = '0;
      size_limit   = cfg_max_bytes;
      nak_left     = '0;
      rrq_left     = cfg_retry_limit;
      xfer_phase   = PH_RUN;
      xfer_outcome = OUT_RUNNING;
      r.send_kind  = resend_rrq(SEND_NONE);
    end else if (xfer_phase == PH_RUN && e.func == FN_TIMEOUT) begin
      r.send_kind = spend_nak(SEND_NONE);
    end else if (xfer_phase == PH_RUN && e.func == FN_PACKET) begin
      if (e.opcode == OP_ERROR) begin
        close_xfer(OUT_ERROR);
      end else if (e.opcode != OP_DATA) begin
        r.packet_status = PS_BADOP;
        r.send_kind     = spend_nak(SEND_NONE);
      end else if (e.blk != next_block) begin
        r.packet_status = PS_BADBLOCK;
        r.send_kind     = spend_nak(SEND_NONE);
      end else begin
        // right block: the block count moves on; acked unless a resent read request goes instead
        plen        = e.ulen - HDR_BYTES;
        next_block  = next_block + 1'b1;
        r.ack_block = e.blk;
        if (plen > BLK_BYTES) begin
          r.packet_status = PS_OVERSIZE;
          r.send_kind     = spend_nak(SEND_ACK);
        end else if ({1'b0, rx_bytes} + plen > {1'b0, size_limit}) begin
          r.packet_status = PS_OVERFLOW;
          r.send_kind     = spend_nak(SEND_ACK);
        end else begin
          r.packet_status = PS_ACCEPTED;
          r.send_kind     = SEND_ACK;
          r.store_enable  = 1'b1;
          r.store_offset  = rx_bytes;
          r.store_length  = plen[STLEN_W-1:0];
          rx_bytes        = rx_bytes + plen;
          if (plen < BLK_BYTES) size_limit = rx_bytes;  // short block fixes the size
          nak_left = fresh_naks();
          if (rx_bytes == size_limit) close_xfer(OUT_DONE);
        end
      end
      if (r.send_kind != SEND_ACK) r.ack_block = '0;
    end
    r.bytes_so_far = rx_bytes;
    r.outcome      = (xfer_phase == PH_END) ? xfer_outcome : OUT_RUNNING;
    return r;
  endfunction

  task automatic report_fault(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // event driver: one word held until accepted, gaps drawn per cycle
  // ---------------------------------------------------------------------------
  hdr_evt_t cur_evt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_ch.valid        <= 1'b0;
      evt_ch.func         <= FN_UNUSED;
      evt_ch.opcode       <= '0;
      evt_ch.block_number <= '0;
      evt_ch.udp_length   <= '0;
    end else begin
      // accepted word: predict its reply now, in acceptance order
      if (evt_ch.valid && evt_ch.ready) expected_replies.push_back(predict_reply(cur_evt));
      if (!evt_ch.valid || evt_ch.ready) begin
        if (hdr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_evt = hdr_queue.pop_front();
          evt_ch.valid        <= 1'b1;
          evt_ch.func         <= cur_evt.func;
          evt_ch.opcode       <= cur_evt.opcode;
          evt_ch.block_number <= cur_evt.blk;
          evt_ch.udp_length   <= cur_evt.ulen;
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reply monitor: random back-pressure plus two long hold-offs
  // ---------------------------------------------------------------------------
  int words_seen;
  int hold_cycles;

  task automatic check_reply();
    res_t want;
    if (expected_replies.size() == 0) begin
      report_fault($sformatf("reply word with nothing expected, send_kind %0d",
                             res_ch.send_kind));
    end else begin
      want = expected_replies.pop_front();
      if (res_ch.send_kind !== want.send_kind)
        report_fault($sformatf("word %0d send_kind got %0d want %0d",
                               words_seen, res_ch.send_kind, want.send_kind));
      if (res_ch.ack_block !== want.ack_block)
        report_fault($sformatf("word %0d ack_block got %0d want %0d",
                               words_seen, res_ch.ack_block, want.ack_block));
      if (res_ch.store_enable !== want.store_enable)
        report_fault($sformatf("word %0d store_enable got %0d want %0d",
                               words_seen, res_ch.store_enable, want.store_enable));
      if (res_ch.store_offset !== want.store_offset)
        report_fault($sformatf("word %0d store_offset got %0d want %0d",
                               words_seen, res_ch.store_offset, want.store_offset));
      if (res_ch.store_length !== want.store_length)
        report_fault($sformatf("word %0d store_length got %0d want %0d",
                               words_seen, res_ch.store_length, want.store_length));
      if (res_ch.bytes_so_far !== want.bytes_so_far)
        report_fault($sformatf("word %0d bytes_so_far got %0d want %0d",
                               words_seen, res_ch.bytes_so_far, want.bytes_so_far));
      if (res_ch.outcome !== want.outcome)
        report_fault($sformatf("word %0d outcome got %0d want %0d",
                               words_seen, res_ch.outcome, want.outcome));
      if (res_ch.packet_status !== want.packet_status)
        report_fault($sformatf("word %0d packet_status got %0d want %0d",
                               words_seen, res_ch.packet_status, want.packet_status));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      words_seen  = 0;
      hold_cycles = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        check_reply();
        words_seen++;
        // stall the output for a long while; the sender keeps offering words
        if (words_seen == 350 || words_seen == 850) hold_cycles = LONG_HOLD;
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a hang shows up as a long run of cycles with nothing moving
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_evt(func_e f, logic [HALF_W-1:0] op, logic [HALF_W-1:0] blk,
                          logic [HALF_W-1:0] ulen);
    hdr_evt_t e;
    e.func   = f;
    e.opcode = op;
    e.blk    = blk;
    e.ulen   = ulen;
    hdr_queue.push_back(e);
    gen_count++;
  endtask

  // data packet carrying plen payload bytes
  task automatic push_data(logic [HALF_W-1:0] blk, logic [HALF_W-1:0] plen);
    push_evt(FN_PACKET, OP_DATA, blk, plen + HDR_BYTES);
  endtask

  // register writes only while the engine holds nothing in flight
  task automatic write_reg(cfg_idx_e idx, logic [PORT_LEN-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == CFG_MAX_BYTES) cfg_max_bytes = val;
    else cfg_retry_limit = val[RETRY_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued event is accepted and every reply has come back
  task automatic settle();
    while (hdr_queue.size() != 0 || evt_ch.valid || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one mostly well-formed transfer with random faults mixed in
  task automatic gen_transfer();
    logic [HALF_W-1:0] blk;
    logic [HALF_W-1:0] plen;
    int                steps;
    int                pick;
    int                len_pick;
    bit                over;
    blk   = 16'd1;
    over  = 1'b0;
    // now and then a fully random word ahead of the start
    if ($urandom_range(9) == 0)
      push_evt(func_e'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom));
    push_evt(FN_START, 16'($urandom), 16'($urandom), 16'($urandom));
    steps = $urandom_range(1, 24);
    for (int s = 0; s < steps && !over; s++) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        len_pick = $urandom_range(19);
        if (len_pick < 14) begin
          push_data(blk, 16'(BLK_BYTES));
        end else if (len_pick < 17) begin
          push_data(blk, 16'($urandom_range(0, BLK_BYTES - 1)));
          over = 1'b1;  // short block closes the transfer
        end else if (len_pick < 18) begin
          push_data(blk, 16'($urandom_range(BLK_BYTES + 1, 1100)));
        end else begin
          push_evt(FN_PACKET, OP_DATA, blk, 16'($urandom));
        end
        blk = blk + 1'b1;
      end else if (pick < 78) begin
        push_evt(FN_TIMEOUT, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 84) begin
        push_evt(FN_PACKET, OP_DATA, blk + 16'($urandom_range(1, 65535)), 16'($urandom));
      end else if (pick < 88) begin
        push_data(blk - 1'b1, 16'(BLK_BYTES));  // duplicate of the last block
      end else if (pick < 93) begin
        push_evt(FN_PACKET, 16'($urandom), blk, 16'($urandom));
      end else if (pick < 95) begin
        push_evt(FN_PACKET, OP_ERROR, 16'($urandom), 16'($urandom));
        over = 1'b1;
      end else if (pick < 97) begin
        push_evt(FN_START, 16'($urandom), 16'($urandom), 16'($urandom));
        blk = 16'd1;
      end else begin
        push_evt(FN_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    // sometimes poke the engine once it has finished
    if (over && $urandom_range(3) == 0) push_data(blk, 16'(BLK_BYTES));
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int seg_start;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, registers at their reset values
    // idle engine ignores packets, timeouts and the unused event code
    push_data(16'd1, 16'(BLK_BYTES));
    push_evt(FN_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_evt(FN_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_evt(FN_START, 16'h0000, 16'h0000, 16'h0000);
    push_data(16'd1, 16'(BLK_BYTES));
    push_evt(FN_PACKET, OP_DATA, 16'd2, 16'hFFFF);        // far too long, still acked
    push_evt(FN_PACKET, OP_DATA, 16'hFFFF, 16'd524);      // wrong block
    push_evt(FN_PACKET, 16'hFFFF, 16'd3, 16'd524);        // unknown opcode
    push_evt(FN_PACKET, 16'h0000, 16'd3, 16'd524);
    push_evt(FN_TIMEOUT, 16'h0000, 16'h0000, 16'h0000);
    push_evt(FN_PACKET, OP_DATA, 16'd3, 16'd11);          // length below header wraps
    push_evt(FN_PACKET, OP_DATA, 16'd4, 16'd12);          // empty block ends the transfer
    push_data(16'd5, 16'(BLK_BYTES));                     // ignored once finished
    push_evt(FN_START, 16'h0000, 16'h0000, 16'h0000);
    push_evt(FN_PACKET, OP_ERROR, 16'd1, 16'd524);        // error packet fails it
    settle();

    // zero-size image: done straight after the read request
    write_reg(CFG_MAX_BYTES, '0);
    write_reg(CFG_RETRY_LIMIT, 24'd1);
    push_evt(FN_START, 16'h0000, 16'h0000, 16'h0000);
    settle();

    // single retry: three timeouts use it up; then overflow of a small image
    write_reg(CFG_MAX_BYTES, 24'd1000);
    push_evt(FN_START, 16'h0000, 16'h0000, 16'h0000);
    repeat (3) push_evt(FN_TIMEOUT, 16'h0000, 16'h0000, 16'h0000);
    push_evt(FN_START, 16'h0000, 16'h0000, 16'h0000);
    push_data(16'd1, 16'(BLK_BYTES));
    push_data(16'd2, 16'(BLK_BYTES));
    settle();

    // no retries at all: the start fails on the spot
    write_reg(CFG_RETRY_LIMIT, '0);
    push_evt(FN_START, 16'h0000, 16'h0000, 16'h0000);
    push_data(16'd1, 16'(BLK_BYTES));
    settle();

    // random part: three idling modes, two register settings in each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        settle();
        case (mode * 2 + seg)
          0: begin
            write_reg(CFG_MAX_BYTES, 24'hFF_FFFF);
            write_reg(CFG_RETRY_LIMIT, 24'd255);
          end
          1: begin
            write_reg(CFG_MAX_BYTES, 24'd1500);
            write_reg(CFG_RETRY_LIMIT, 24'd1);
          end
          2: begin
            write_reg(CFG_MAX_BYTES, 24'($urandom_range(0, 8000)));
            write_reg(CFG_RETRY_LIMIT, 24'($urandom_range(1, 4)));
          end
          3: begin
            write_reg(CFG_MAX_BYTES, 24'hFF_FFFF);
            write_reg(CFG_RETRY_LIMIT, 24'($urandom_range(1, 255)));
          end
          4: begin
            write_reg(CFG_MAX_BYTES, 24'($urandom_range(512, 3000)));
            write_reg(CFG_RETRY_LIMIT, 24'd2);
          end
          default: begin
            write_reg(CFG_MAX_BYTES, 24'($urandom_range(0, 20000)));
            write_reg(CFG_RETRY_LIMIT, 24'($urandom_range(1, 16)));
          end
        endcase
        seg_start = gen_count;
        while (gen_count - seg_start < 170) gen_transfer();
      end
    end

    // let the last words drain, then a short tail for anything stray
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
